// ===== hdl/itda_pkg.sv =====
// Shared widths and character codes for the integer to decimal ASCII converter.
package itda_pkg;

  localparam int VALUE_W   = 32;
  localparam int CAP_W     = 16;
  localparam int CHAR_W    = 8;
  localparam int NUM_DIGITS = 10;
  localparam int BCD_W     = 4 * NUM_DIGITS;
  localparam int BIT_CNT_W = $clog2(VALUE_W + 1);
  localparam int NDIG_W    = $clog2(NUM_DIGITS + 1);

  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [3:0]        DIGIT_HI   = 4'h3;

endpackage

// ===== hdl/int_to_decimal_ascii.sv =====
// Top level: converts one 32-bit value per item to NUL-terminated decimal ASCII text.
//
//  Channel   Direction  tdata                           tuser   tlast
//  s_*       in         value[31:0], capacity[47:32]    op      -
//  m_*       out        character[7:0]                  ok      last
//
// An item passes through acceptance, bit-serial conversion, stripping of one leading zero
// per cycle and a length check, then one output character per cycle while m_tready allows;
// when the text does not fit, only a terminator with ok low is emitted.
// The next item is accepted in the cycle after the terminator enters the output register.
// Reset is synchronous and clears the control state only; a stalled m_tready
// simply holds the output register and pauses emission.
module int_to_decimal_ascii
  import itda_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [VALUE_W+CAP_W-1:0]  s_tdata,   // value[31:0], capacity[47:32]
  input  logic                      s_tuser,   // op
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [CHAR_W-1:0]         m_tdata,   // character[7:0]
  output logic                      m_tuser,   // ok
  output logic                      m_tlast
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CONV  = 6'b000010,
    S_NORM  = 6'b000100,
    S_SIGN  = 6'b001000,
    S_DIGIT = 6'b010000,
    S_TERM  = 6'b100000
  } state_t;

  state_t             state;
  logic               negative;
  logic               ok;
  logic [CAP_W-1:0]   capacity;
  logic [BCD_W-1:0]   digits;
  logic [NDIG_W-1:0]  ndig;
  logic [VALUE_W-1:0] magnitude;
  logic               conv_start;
  logic               conv_done;
  logic [BCD_W-1:0]   conv_bcd;
  logic               out_load;
  logic               emit;
  logic               accept;
  logic               in_neg;
  logic [3:0]         need;
  logic               fits;

  assign accept     = s_tvalid && s_tready;
  assign s_tready   = (state == S_IDLE);
  assign in_neg     = s_tuser && s_tdata[VALUE_W-1];
  assign magnitude  = in_neg ? (~s_tdata[VALUE_W-1:0] + 1'b1) : s_tdata[VALUE_W-1:0];
  assign conv_start = accept;
  assign out_load   = !m_tvalid || m_tready;
  assign emit       = out_load && (state == S_SIGN || state == S_DIGIT || state == S_TERM);
  assign need       = 4'(negative) + 4'(ndig) + 4'd1;
  assign fits       = (CAP_W'(need) <= capacity);

  itda_bcd u_bcd (
    .clk   (clk),
    .rst   (rst),
    .start (conv_start),
    .value (magnitude),
    .done  (conv_done),
    .bcd   (conv_bcd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_CONV;
          end
        end
        S_CONV: begin
          if (conv_done) begin
            state <= S_NORM;
          end
        end
        S_NORM: begin
          if (!(digits[BCD_W-1 -: 4] == 4'd0 && ndig > NDIG_W'(1))) begin
            if (!fits) begin
              state <= S_TERM;
            end else if (negative) begin
              state <= S_SIGN;
            end else begin
              state <= S_DIGIT;
            end
          end
        end
        S_SIGN: begin
          if (out_load) begin
            state <= S_DIGIT;
          end
        end
        S_DIGIT: begin
          if (out_load) begin
            if (ndig == NDIG_W'(1)) begin
              state <= S_TERM;
            end
          end
        end
        S_TERM: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          negative <= in_neg;
          capacity <= s_tdata[VALUE_W +: CAP_W];
        end
      end
      S_CONV: begin
        if (conv_done) begin
          digits <= conv_bcd;
          ndig   <= NDIG_W'(NUM_DIGITS);
        end
      end
      S_NORM: begin
        // Strip one leading zero digit per cycle, keeping at least one digit.
        if (digits[BCD_W-1 -: 4] == 4'd0 && ndig > NDIG_W'(1)) begin
          digits <= {digits[BCD_W-5:0], 4'd0};
          ndig   <= ndig - 1'b1;
        end else begin
          ok <= fits;
        end
      end
      S_SIGN: begin
        if (out_load) begin
          m_tdata <= CHAR_MINUS;
          m_tlast <= 1'b0;
          m_tuser <= 1'b1;
        end
      end
      S_DIGIT: begin
        if (out_load) begin
          m_tdata <= {DIGIT_HI, digits[BCD_W-1 -: 4]};
          m_tlast <= 1'b0;
          m_tuser <= 1'b1;
          digits  <= {digits[BCD_W-5:0], 4'd0};
          ndig    <= ndig - 1'b1;
        end
      end
      S_TERM: begin
        if (out_load) begin
          m_tdata <= CHAR_NUL;
          m_tlast <= 1'b1;
          m_tuser <= ok;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTH
  a_fail_is_terminator: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tlast && m_tdata == CHAR_NUL))
    else $error("failure item is not a lone terminator");

  a_accept_starts_conv: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_CONV))
    else $error("accepted item did not start conversion");

  a_done_in_conv: assert property (@(posedge clk) disable iff (rst)
    conv_done |-> (state == S_CONV))
    else $error("conversion finished outside the conversion phase");

  a_digit_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIGIT) |-> (ndig != '0 && ndig <= NDIG_W'(NUM_DIGITS)))
    else $error("digit count out of range while emitting");
`endif

endmodule

// ===== hdl/itda_bcd.sv =====
// Bit-serial binary to BCD converter using the shift-and-add-three method.
module itda_bcd
  import itda_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [VALUE_W-1:0] value,
  output logic               done,
  output logic [BCD_W-1:0]   bcd
);

  logic [VALUE_W-1:0]   bin;
  logic [BIT_CNT_W-1:0] count;
  logic [BCD_W-1:0]     bcd_adj;

  // Each digit of five or more is corrected before the shift doubles it.
  always_comb begin
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (bcd[4*d +: 4] >= 4'd5) begin
        bcd_adj[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
      end else begin
        bcd_adj[4*d +: 4] = bcd[4*d +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        count <= BIT_CNT_W'(VALUE_W);
      end else if (count != '0) begin
        count <= count - 1'b1;
        done  <= (count == BIT_CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bin <= value;
      bcd <= '0;
    end else if (count != '0) begin
      bin <= {bin[VALUE_W-2:0], 1'b0};
      bcd <= {bcd_adj[BCD_W-2:0], bin[VALUE_W-1]};
    end
  end

endmodule

// ===== tb/tb_int_to_decimal_ascii.sv =====
// Self-checking testbench for the integer to decimal ASCII converter.
module tb_int_to_decimal_ascii;
  import itda_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic OP_UNSIGNED = 1'b0;
  localparam logic OP_SIGNED   = 1'b1;
  localparam int   RANDOM_ITEMS = 145;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
    logic              ok;
  } text_char_t;

  logic                     clk;
  logic                     rst;
  logic                     s_tvalid;
  logic                     s_tready;
  logic [VALUE_W+CAP_W-1:0] s_tdata;
  logic                     s_tuser;
  logic                     m_tvalid;
  logic                     m_tready;
  logic [CHAR_W-1:0]        m_tdata;
  logic                     m_tuser;
  logic                     m_tlast;

  text_char_t expected_text[$];
  int         errors = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;

  int_to_decimal_ascii DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Number of bytes the text needs: sign, digits and terminator.
  function automatic int text_length(input logic op, input logic [VALUE_W-1:0] value);
    logic [VALUE_W-1:0] mag;
    int                 len;
    len = 1;
    mag = value;
    if (op == OP_SIGNED && value[VALUE_W-1]) begin
      mag = ~value + 1'b1;
      len++;
    end
    do begin
      mag = mag / 10;
      len++;
    end while (mag != 0);
    return len;
  endfunction

  function automatic void predict_text(input logic op, input logic [VALUE_W-1:0] value,
                                       input logic [CAP_W-1:0] capacity);
    logic [VALUE_W-1:0] mag;
    logic [3:0]         digits[NUM_DIGITS];
    int                 count;
    text_char_t         entry;
    count = 0;
    mag = value;
    if (int'(capacity) < text_length(op, value)) begin
      entry = '{character: CHAR_NUL, last: 1'b1, ok: 1'b0};
      expected_text.push_back(entry);
      return;
    end
    if (op == OP_SIGNED && value[VALUE_W-1]) begin
      mag = ~value + 1'b1;
      entry = '{character: CHAR_MINUS, last: 1'b0, ok: 1'b1};
      expected_text.push_back(entry);
    end
    // Digits come out least significant first and are sent the other way round.
    do begin
      digits[count] = 4'(mag % 10);
      mag = mag / 10;
      count++;
    end while (mag != 0);
    for (int i = count - 1; i >= 0; i--) begin
      entry = '{character: {DIGIT_HI, digits[i]}, last: 1'b0, ok: 1'b1};
      expected_text.push_back(entry);
    end
    entry = '{character: CHAR_NUL, last: 1'b1, ok: 1'b1};
    expected_text.push_back(entry);
  endfunction

  // Called at a falling edge; returns at a falling edge.
  task automatic send_conversion(input logic op, input logic [VALUE_W-1:0] value,
                                 input logic [CAP_W-1:0] capacity);
    s_tvalid <= 1'b1;
    s_tdata  <= {capacity, value};
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    predict_text(op, value, capacity);
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  task automatic wait_for_text_drain();
    s_tvalid <= 1'b0;
    while (expected_text.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : check_text
    text_char_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_text.size() == 0) begin
        errors++;
        $display("%0t: unexpected item, expected none, actual char %h ok %b last %b",
                 $time, m_tdata, m_tuser, m_tlast);
      end else begin
        want = expected_text.pop_front();
        if (m_tdata !== want.character || m_tlast !== want.last || m_tuser !== want.ok) begin
          errors++;
          $display("%0t: expected char %h ok %b last %b, actual char %h ok %b last %b",
                   $time, want.character, want.ok, want.last, m_tdata, m_tuser, m_tlast);
        end
      end
    end
  end

  task automatic test_directed_extremes();
    send_conversion(OP_UNSIGNED, 32'd0, 16'd2);
    send_conversion(OP_UNSIGNED, 32'd0, 16'd1);
    send_conversion(OP_UNSIGNED, 32'd7, 16'd0);
    send_conversion(OP_SIGNED, 32'd5, 16'd1);
    send_conversion(OP_SIGNED, 32'd0, 16'd2);
    send_conversion(OP_UNSIGNED, 32'hFFFF_FFFF, 16'd11);
    send_conversion(OP_UNSIGNED, 32'hFFFF_FFFF, 16'd10);
    send_conversion(OP_SIGNED, 32'h8000_0000, 16'd12);
    send_conversion(OP_SIGNED, 32'h8000_0000, 16'd11);
    send_conversion(OP_SIGNED, 32'h7FFF_FFFF, 16'd11);
    send_conversion(OP_SIGNED, 32'hFFFF_FFFF, 16'd3);
    send_conversion(OP_SIGNED, 32'hFFFF_FFFF, 16'd2);
    send_conversion(OP_UNSIGNED, 32'h8000_0000, 16'd11);
    send_conversion(OP_UNSIGNED, 32'd12345, 16'hFFFF);
    send_conversion(OP_SIGNED, 32'hFFFF_FFF6, 16'hFFFF);
    send_conversion(OP_UNSIGNED, 32'd9, 16'd2);
    send_conversion(OP_UNSIGNED, 32'd10, 16'd3);
    send_conversion(OP_UNSIGNED, 32'd10, 16'd2);
    send_conversion(OP_UNSIGNED, 32'd1_000_000_000, 16'd11);
    send_conversion(OP_UNSIGNED, 32'd999_999_999, 16'd10);
    send_conversion(OP_SIGNED, 32'hFFFF_FFFF, 16'd0);
    send_conversion(OP_UNSIGNED, 32'hFFFF_FFFF, 16'hFFFF);
  endtask

  // The sender holds off until the converter has emitted everything.
  task automatic test_pause_until_drained();
    send_conversion(OP_SIGNED, 32'h8000_0001, 16'd12);
    send_conversion(OP_UNSIGNED, 32'd42, 16'd3);
    wait_for_text_drain();
    send_conversion(OP_SIGNED, 32'd42, 16'd4);
  endtask

  task automatic test_random_conversions(input int idle_pct, input int stall_pct);
    logic               op;
    logic [VALUE_W-1:0] value;
    logic [CAP_W-1:0]   capacity;
    logic [VALUE_W-1:0] pw;
    int                 need;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (RANDOM_ITEMS) begin
      op = 1'($urandom);
      case ($urandom_range(7))
        0, 1: value = $urandom;
        2: value = $urandom_range(0, 99);
        3: begin
          pw = 1;
          repeat ($urandom_range(0, 9)) pw = pw * 10;
          value = pw + $urandom_range(0, 2) - 1;
        end
        4: value = 32'd0 - $urandom_range(1, 100);
        5: value = 32'h8000_0000 + $urandom_range(0, 3);
        6: value = 32'hFFFF_FFFF - $urandom_range(0, 3);
        default: value = $urandom >> $urandom_range(0, 31);
      endcase
      need = text_length(op, value);
      // Most capacities sit around the required length so both sides of the limit are hit.
      case ($urandom_range(9))
        6: capacity = CAP_W'($urandom_range(0, 65535));
        7: capacity = 16'($urandom);
        8: capacity = CAP_W'($urandom_range(0, 2));
        9: capacity = CAP_W'(16'hFFFF - $urandom_range(0, 3));
        default: capacity = CAP_W'(need - 1 + $urandom_range(0, 3));
      endcase
      send_conversion(op, value, capacity);
    end
  endtask

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    send_idle_pct  = 33;
    recv_stall_pct = 52;
    test_directed_extremes();
    test_pause_until_drained();
    test_random_conversions(33, 52);
    test_random_conversions(52, 33);
    test_random_conversions(0, 0);
    wait_for_text_drain();
    repeat (60) @(posedge clk);
    if (expected_text.size() != 0) begin
      errors++;
      $display("%0t: expected %0d more items, actual none", $time, expected_text.size());
    end
    if (errors == 0) begin
      $display("int_to_decimal_ascii: match");
    end else begin
      $display("int_to_decimal_ascii: mismatch");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("int_to_decimal_ascii: mismatch");
    $finish;
  end

endmodule
